// ===== rtl/fmrpd_pkg.sv =====
// Shared types, widths and constants for the four-motor ramp PWM driver.
// No dependencies; every other file of the block imports this package.
package fmrpd_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int SPEED_W    = 8;
  localparam int DIFF_W     = SPEED_W + 1;
  localparam int STEP_W     = 7;
  localparam int MAG_W      = 7;
  localparam int DUTY_W     = 8;
  localparam int TIME_W     = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNITUDE_MASK = 3'd4;

  localparam logic                  RST_RAMP_MODE = 1'b0;
  localparam logic [STEP_W-1:0]     RST_STEP_SIZE = 7'd3;
  localparam logic [MAG_W-1:0]      RST_SPEED_CAP = 7'd100;
  localparam logic [NUM_MOTORS-1:0] RST_MASK      = 4'd0;

  // ramp updates only when strictly more than this many ms have passed
  localparam logic [TIME_W-1:0] MIN_ELAPSED_MS = 32'd1;

  // |s|*255/100 == (|s| * DUTY_RECIP) >> DUTY_SHIFT for |s| <= 127
  // (255 * ceil(2^19/100) folded into one constant)
  localparam int DUTY_SHIFT  = 19;
  localparam int PROD_W      = 28;
  localparam int QUOT_W      = PROD_W - DUTY_SHIFT;
  localparam logic [PROD_W-1:0] DUTY_RECIP = 28'd1336965;
  localparam logic [DUTY_W-1:0] FULL_DUTY  = 8'd255;

  typedef logic signed [SPEED_W-1:0] speed_t;

  typedef struct packed {
    logic              advance;
    logic              ramp_mode;
    logic [STEP_W-1:0] step_size;
  } ramp_ctl_t;

  typedef struct packed {
    logic [MAG_W-1:0] speed_cap;
    logic             reverse;
    logic             magnitude;
  } drive_cfg_t;

endpackage

// ===== rtl/fmrpd_in_if.sv =====
// Command channel: four target speeds and a millisecond timestamp per word.
// Depends on fmrpd_pkg.
interface fmrpd_in_if
  import fmrpd_pkg::*;
;
  logic              valid;
  logic              ready;
  speed_t            target_one;
  speed_t            target_two;
  speed_t            target_three;
  speed_t            target_four;
  logic [TIME_W-1:0] now_ms;

  modport source (
    output valid, target_one, target_two, target_three, target_four, now_ms,
    input  ready
  );
  modport sink (
    input  valid, target_one, target_two, target_three, target_four, now_ms,
    output ready
  );
endinterface

// ===== rtl/fmrpd_out_if.sv =====
// Result channel: direction bit and PWM duty for each of the four motors.
// Depends on fmrpd_pkg.
interface fmrpd_out_if
  import fmrpd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              dir_one;
  logic [DUTY_W-1:0] duty_one;
  logic              dir_two;
  logic [DUTY_W-1:0] duty_two;
  logic              dir_three;
  logic [DUTY_W-1:0] duty_three;
  logic              dir_four;
  logic [DUTY_W-1:0] duty_four;

  modport source (
    output valid, dir_one, duty_one, dir_two, duty_two,
           dir_three, duty_three, dir_four, duty_four,
    input  ready
  );
  modport sink (
    input  valid, dir_one, duty_one, dir_two, duty_two,
           dir_three, duty_three, dir_four, duty_four,
    output ready
  );
endinterface

// ===== rtl/four_motor_ramp_pwm_driver.sv =====
// Top level of the four-motor ramp PWM driver.
// Depends on fmrpd_pkg, fmrpd_in_if, fmrpd_out_if, fmrpd_ramp, fmrpd_drive.
//
// Usage:
//  - in_ch carries one command word: four signed target speeds (percent)
//    and a millisecond timestamp. out_ch returns one word per command with
//    a direction bit and an 8-bit PWM duty for each motor.
//  - cfg_we/cfg_index/cfg_wdata write the mode, ramp step, speed clamp and
//    the per-motor reverse and magnitude-duty masks; write only when idle.
//  - The command word is registered, then ramp update, reverse/clamp and
//    duty scaling run in one pass into the result register.
//  - Throughput is one word per cycle unless out_ch stalls. The only loop
//    is the kept-speed and timestamp state, updated in the same cycle the
//    word leaves stage 1, so back-to-back words see each other's ramp steps.
//  - in_ch.ready stays high while the result register is empty or being
//    drained. When the receiver stalls, one finished word waits in the
//    result register and one more can sit in the input register; then
//    ready drops until out_ch.ready returns.
//  - Synchronous reset clears the valid flags, kept speeds, last update
//    time and configuration (direct mode, step 3, clamp 100, masks 0).
module four_motor_ramp_pwm_driver
  import fmrpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fmrpd_in_if.sink              in_ch,
  fmrpd_out_if.source           out_ch
);

  // configuration registers
  logic                  ramp_mode_r;
  logic [STEP_W-1:0]     step_size_r;
  logic [MAG_W-1:0]      speed_cap_r;
  logic [NUM_MOTORS-1:0] reverse_r;
  logic [NUM_MOTORS-1:0] magnitude_r;

  // input register stage
  logic              s1_valid_r;
  speed_t            s1_tgt_r [NUM_MOTORS];
  logic [TIME_W-1:0] s1_now_r;

  // result register stage
  logic              out_valid_r;
  logic              out_dir_r  [NUM_MOTORS];
  logic [DUTY_W-1:0] out_duty_r [NUM_MOTORS];

  logic              in_acc;
  logic              adv;
  ramp_ctl_t         ramp_ctl;
  speed_t            use_spd  [NUM_MOTORS];
  logic              dir_c    [NUM_MOTORS];
  logic [DUTY_W-1:0] duty_c   [NUM_MOTORS];

  // stage 1 moves on when the result register is free or being taken
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_mode_r <= RST_RAMP_MODE;
      step_size_r <= RST_STEP_SIZE;
      speed_cap_r <= RST_SPEED_CAP;
      reverse_r   <= RST_MASK;
      magnitude_r <= RST_MASK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RAMP_MODE:      ramp_mode_r <= cfg_wdata[0];
        CFG_STEP_SIZE:      step_size_r <= cfg_wdata[STEP_W-1:0];
        CFG_SPEED_CAP:      speed_cap_r <= cfg_wdata[MAG_W-1:0];
        CFG_REVERSE_MASK:   reverse_r   <= cfg_wdata[NUM_MOTORS-1:0];
        CFG_MAGNITUDE_MASK: magnitude_r <= cfg_wdata[NUM_MOTORS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tgt_r[0] <= in_ch.target_one;
      s1_tgt_r[1] <= in_ch.target_two;
      s1_tgt_r[2] <= in_ch.target_three;
      s1_tgt_r[3] <= in_ch.target_four;
      s1_now_r    <= in_ch.now_ms;
    end
  end

  // ramp state advances only with the word that leaves stage 1
  assign ramp_ctl = '{advance: adv, ramp_mode: ramp_mode_r, step_size: step_size_r};

  fmrpd_ramp u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ramp_ctl),
    .tgt     (s1_tgt_r),
    .now_ms  (s1_now_r),
    .use_spd (use_spd)
  );

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_drive
    fmrpd_drive u_drive (
      .spd  (use_spd[m]),
      .cfg  (drive_cfg_t'{speed_cap: speed_cap_r, reverse: reverse_r[m],
                          magnitude: magnitude_r[m]}),
      .dir  (dir_c[m]),
      .duty (duty_c[m])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        out_dir_r[i]  <= dir_c[i];
        out_duty_r[i] <= duty_c[i];
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dir_one    = out_dir_r[0];
  assign out_ch.duty_one   = out_duty_r[0];
  assign out_ch.dir_two    = out_dir_r[1];
  assign out_ch.duty_two   = out_duty_r[1];
  assign out_ch.dir_three  = out_dir_r[2];
  assign out_ch.duty_three = out_duty_r[2];
  assign out_ch.dir_four   = out_dir_r[3];
  assign out_ch.duty_four  = out_duty_r[3];

endmodule

// ===== rtl/fmrpd_ramp.sv =====
// Slew-rate limiter: holds the kept speed per motor and the last update time.
// Depends on fmrpd_pkg.
module fmrpd_ramp
  import fmrpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ramp_ctl_t         ctl,
  input  speed_t            tgt [NUM_MOTORS],
  input  logic [TIME_W-1:0] now_ms,
  output speed_t            use_spd [NUM_MOTORS]
);

  speed_t            kept_r   [NUM_MOTORS];
  speed_t            kept_nxt [NUM_MOTORS];
  logic [TIME_W-1:0] last_ms_r;
  logic [TIME_W-1:0] elapsed;
  logic              upd;

  // move k toward t by step, snap when closer than one step
  function automatic speed_t step_toward(speed_t k, speed_t t,
                                         logic [STEP_W-1:0] step);
    logic signed [DIFF_W-1:0] diff;
    logic        [DIFF_W-1:0] dmag;
    logic signed [DIFF_W-1:0] stp;
    logic signed [DIFF_W-1:0] sum;
    diff = {t[SPEED_W-1], t} - {k[SPEED_W-1], k};
    dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    stp  = signed'(DIFF_W'(step));
    if (dmag < DIFF_W'(step)) begin
      sum = {t[SPEED_W-1], t};
    end else if (diff[DIFF_W-1]) begin
      sum = {k[SPEED_W-1], k} - stp;
    end else begin
      sum = {k[SPEED_W-1], k} + stp;
    end
    return sum[SPEED_W-1:0];
  endfunction

  assign elapsed = now_ms - last_ms_r;  // wraps modulo 2^32
  assign upd     = ctl.ramp_mode && (elapsed > MIN_ELAPSED_MS);

  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      kept_nxt[i] = upd ? step_toward(kept_r[i], tgt[i], ctl.step_size) : kept_r[i];
      use_spd[i]  = ctl.ramp_mode ? kept_nxt[i] : tgt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        kept_r[i] <= '0;
      end
      last_ms_r <= '0;
    end else if (ctl.advance && upd) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        kept_r[i] <= kept_nxt[i];
      end
      last_ms_r <= now_ms;
    end
  end

endmodule

// ===== rtl/fmrpd_drive.sv =====
// One motor's output stage: reverse, clamp, direction and duty scaling.
// Depends on fmrpd_pkg.
module fmrpd_drive
  import fmrpd_pkg::*;
(
  input  speed_t            spd,
  input  drive_cfg_t        cfg,
  output logic              dir,
  output logic [DUTY_W-1:0] duty
);

  logic signed [DIFF_W-1:0] s_ext;
  logic signed [DIFF_W-1:0] s_rev;
  logic signed [DIFF_W-1:0] lim;
  logic signed [DIFF_W-1:0] s_clp;
  logic        [DIFF_W-1:0] s_abs;
  logic        [PROD_W-1:0] prod;
  logic        [QUOT_W-1:0] quot;

  assign s_ext = {spd[SPEED_W-1], spd};
  assign s_rev = cfg.reverse ? DIFF_W'(-s_ext) : s_ext;  // -128 becomes +128
  assign lim   = signed'(DIFF_W'(cfg.speed_cap));

  always_comb begin
    if (s_rev > lim) begin
      s_clp = lim;
    end else if (s_rev < -lim) begin
      s_clp = DIFF_W'(-lim);
    end else begin
      s_clp = s_rev;
    end
  end

  assign s_abs = s_clp[DIFF_W-1] ? DIFF_W'(-s_clp) : DIFF_W'(s_clp);
  assign prod  = PROD_W'(s_abs[MAG_W-1:0]) * DUTY_RECIP;
  assign quot  = prod[PROD_W-1:DUTY_SHIFT];
  assign dir   = s_clp[DIFF_W-1];

  // duty saturates to 0..255 for speeds beyond +-100
  always_comb begin
    if (!s_clp[DIFF_W-1] || cfg.magnitude) begin
      duty = (quot > QUOT_W'(FULL_DUTY)) ? FULL_DUTY : quot[DUTY_W-1:0];
    end else begin
      duty = (quot > QUOT_W'(FULL_DUTY)) ? '0 : FULL_DUTY - quot[DUTY_W-1:0];
    end
  end

endmodule

// ===== rtl/fmrpd_checker.sv =====
// Port-level checks for four_motor_ramp_pwm_driver, attached with a bind.
// Depends on fmrpd_pkg and the top level's channel interfaces.
module fmrpd_checker
  import fmrpd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] out_duty_one
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // with nothing waiting on the output, a command word is always taken
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  // an accepted word passes the input register and reaches the output if the sink drains
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted word did not reach the output");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_duty_one))
    else $error("stalled result word changed");

endmodule

bind four_motor_ramp_pwm_driver fmrpd_checker u_fmrpd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_duty_one (out_ch.duty_one)
);
